>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the checker file mcg_checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define MCG_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define MCG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/mcg_pkg.sv
// ----------------------------------------------------------------------------
// mcg_pkg
// Widths, codes, constant tables and helpers of the month calendar grid core.
// ----------------------------------------------------------------------------
`default_nettype none

package mcg_pkg;

  localparam int DAY_W       = 5;
  localparam int MONTH_W     = 4;
  localparam int YEAR_W      = 14;
  localparam int KIND_W      = 2;
  localparam int ROW_W       = 3;
  localparam int COL_W       = 3;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 5;
  localparam int CELL_IDX_W  = 6;
  localparam int DAYS_BEFORE_W = 9;

  localparam int GRID_ROWS  = 6;
  localparam int GRID_COLS  = 7;
  localparam int GRID_CELLS = GRID_ROWS * GRID_COLS;

  // Holiday register reset values.
  localparam logic [DAY_W-1:0]   HOL1_DAY_RST   = 5'd1;
  localparam logic [MONTH_W-1:0] HOL1_MONTH_RST = 4'd1;
  localparam logic [DAY_W-1:0]   HOL2_DAY_RST   = 5'd17;
  localparam logic [MONTH_W-1:0] HOL2_MONTH_RST = 4'd8;

  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

  // floor(x / 25) == (x * RECIP_25) >> RECIP_SHIFT for x below 4681.
  localparam logic [10:0] RECIP_25    = 11'd1311;
  localparam int          RECIP_SHIFT = 15;

  // Multiple of 7 added so the century term can be subtracted without wrap.
  localparam logic [7:0] WEEK_BIAS = 8'd168;

  typedef enum logic [KIND_W-1:0] {
    PHASE_PREV = 2'd0,
    PHASE_CUR  = 2'd1,
    PHASE_NEXT = 2'd2
  } grid_phase_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_HOL1_DAY   = 2'd0,
    CFG_HOL1_MONTH = 2'd1,
    CFG_HOL2_DAY   = 2'd2,
    CFG_HOL2_MONTH = 2'd3
  } cfg_index_t;

  // Length of a month 1..12; zero for a month number that means nothing.
  function automatic logic [DAY_W-1:0] month_length(input logic [MONTH_W-1:0] month,
                                                    input logic leap);
    logic [DAY_W-1:0] len;
    unique case (month)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                     len = 5'd30;
      4'd2:                                        len = leap ? 5'd29 : 5'd28;
      default:                                     len = 5'd0;
    endcase
    return len;
  endfunction

  // Days in the year before the first of the month (non-leap count).
  function automatic logic [DAYS_BEFORE_W-1:0] days_before(input logic [MONTH_W-1:0] month);
    logic [DAYS_BEFORE_W-1:0] d;
    unique case (month)
      4'd1:    d = 9'd0;
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

>>> design/mcg_if.sv
// ----------------------------------------------------------------------------
// mcg_if
// Valid/ready channels of the month calendar grid core.
// ----------------------------------------------------------------------------
`default_nettype none

interface mcg_in_if import mcg_pkg::*;;
  logic               valid;
  logic               ready;
  logic [DAY_W-1:0]   given_day;
  logic [MONTH_W-1:0] given_month;
  logic [YEAR_W-1:0]  given_year;

  modport source (output valid, output given_day, output given_month,
                  output given_year, input ready);
  modport sink   (input valid, input given_day, input given_month,
                  input given_year, output ready);
endinterface

interface mcg_out_if import mcg_pkg::*;;
  logic              valid;
  logic              ready;
  logic [DAY_W-1:0]  cell_day;
  logic [KIND_W-1:0] cell_month_kind;
  logic [ROW_W-1:0]  cell_row;
  logic [COL_W-1:0]  cell_column;
  logic              is_red;
  logic              is_selected;
  logic              date_invalid;
  logic              last_cell;

  modport source (output valid, output cell_day, output cell_month_kind,
                  output cell_row, output cell_column, output is_red,
                  output is_selected, output date_invalid, output last_cell,
                  input ready);
  modport sink   (input valid, input cell_day, input cell_month_kind,
                  input cell_row, input cell_column, input is_red,
                  input is_selected, input date_invalid, input last_cell,
                  output ready);
endinterface

interface mcg_cfg_if import mcg_pkg::*;;
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> design/month_calendar_grid_generator_core.sv
// ----------------------------------------------------------------------------
// month_calendar_grid_generator_core
// Checks a Gregorian date and streams its Sunday-first 6x7 month grid.
// ----------------------------------------------------------------------------
// Path: a date passes the three prep stages, the generator and the out reg
//   before its first cell is on the output.
// Flow: 42 cells for a valid date, one for an invalid, one cell a cycle unless
//   the output stalls; up to three dates queue in the prep stages meanwhile.
// Reset: synchronous, active high; empties every stage and loads the holiday
//   registers with 1/1 and 17/8.
`default_nettype none

module month_calendar_grid_generator_core import mcg_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  mcg_cfg_if.sink    cfg,
  mcg_in_if.sink     date,
  mcg_out_if.source  grid
);

  // Context a grid needs while it streams.
  typedef struct packed {
    logic               invalid;
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [MONTH_W-1:0] prev_month;
    logic [MONTH_W-1:0] next_month;
    logic [DAY_W-1:0]   cur_len;
    logic [DAY_W-1:0]   prev_len;
  } grid_ctx_t;

  // Stage B: date plus the two divide-by-25 quotients.
  typedef struct packed {
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
    logic [7:0]         q100;
    logic [5:0]         q400;
  } stage_b_t;

  // Stage C: grid context plus the day count that sets the first weekday.
  typedef struct packed {
    grid_ctx_t ctx;
    logic [14:0] day_sum;
  } stage_c_t;

  // --------------------------------------------------------------------------
  // Holiday registers. Writes are always taken.
  // --------------------------------------------------------------------------
  logic [DAY_W-1:0]   hol1_day;
  logic [MONTH_W-1:0] hol1_month;
  logic [DAY_W-1:0]   hol2_day;
  logic [MONTH_W-1:0] hol2_month;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      hol1_day   <= HOL1_DAY_RST;
      hol1_month <= HOL1_MONTH_RST;
      hol2_day   <= HOL2_DAY_RST;
      hol2_month <= HOL2_MONTH_RST;
    end else if (cfg.valid) begin
      unique case (cfg_index_t'(cfg.index))
        CFG_HOL1_DAY:   hol1_day   <= cfg.data;
        CFG_HOL1_MONTH: hol1_month <= cfg.data[MONTH_W-1:0];
        CFG_HOL2_DAY:   hol2_day   <= cfg.data;
        CFG_HOL2_MONTH: hol2_month <= cfg.data[MONTH_W-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Flow control. Each stage moves when the one after it has room; the
  // generator frees up when a grid's last cell moves into the output register.
  // --------------------------------------------------------------------------
  logic a_valid, b_valid, c_valid;
  logic a_ready, b_ready, c_ready;
  logic out_valid, out_room;
  logic gen_busy, gen_emit, gen_last, gen_free, gen_load;

  assign out_room = !out_valid || grid.ready;
  assign gen_emit = gen_busy && out_room;
  assign gen_free = !gen_busy || (gen_emit && gen_last);
  assign gen_load = c_valid && gen_free;
  assign c_ready  = !c_valid || gen_free;
  assign b_ready  = !b_valid || c_ready;
  assign a_ready  = !a_valid || b_ready;
  assign date.ready = a_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
    end else begin
      if (a_ready) a_valid <= date.valid;
      if (b_ready) b_valid <= a_valid;
      if (c_ready) c_valid <= b_valid;
    end
  end

  // --------------------------------------------------------------------------
  // Stage A: capture the date.
  // --------------------------------------------------------------------------
  logic [DAY_W-1:0]   a_day;
  logic [MONTH_W-1:0] a_month;
  logic [YEAR_W-1:0]  a_year;

  always_ff @(posedge clk) begin
    if (a_ready && date.valid) begin
      a_day   <= date.given_day;
      a_month <= date.given_month;
      a_year  <= date.given_year;
    end
  end

  // --------------------------------------------------------------------------
  // Stage A -> B: year/100 = (year/4)/25 and year/400 = (year/16)/25 by
  // reciprocal multiply.
  // --------------------------------------------------------------------------
  logic [22:0] prod100;
  logic [20:0] prod400;
  stage_b_t    b_next, b_q;

  assign prod100 = 23'(a_year[YEAR_W-1:2]) * 23'(RECIP_25);
  assign prod400 = 21'(a_year[YEAR_W-1:4]) * 21'(RECIP_25);

  always_comb begin
    b_next.day   = a_day;
    b_next.month = a_month;
    b_next.year  = a_year;
    b_next.q100  = prod100[RECIP_SHIFT +: 8];
    b_next.q400  = prod400[RECIP_SHIFT +: 6];
  end

  always_ff @(posedge clk) begin
    if (b_ready && a_valid) b_q <= b_next;
  end

  // --------------------------------------------------------------------------
  // Stage B -> C: leap year, validation, month lengths and the day count
  // (year-1)*365 + (year-1)/4 - (year-1)/100 + (year-1)/400 + days before
  // the month + leap day + 1, reduced with 365 == 1 mod 7, biased to stay positive.
  // --------------------------------------------------------------------------
  logic [11:0]        q100_x25;
  logic [9:0]         q400_x25;
  logic               div100, div400, leap, month_ok;
  logic [YEAR_W-1:0]  y1;
  logic [7:0]         y1_q100;
  logic [5:0]         y1_q400;
  logic [MONTH_W-1:0] prev_m, next_m;
  logic [DAY_W-1:0]   cur_len;
  stage_c_t           c_next, c_q;

  always_comb begin
    q100_x25 = (12'(b_q.q100) << 4) + (12'(b_q.q100) << 3) + 12'(b_q.q100);
    q400_x25 = (10'(b_q.q400) << 4) + (10'(b_q.q400) << 3) + 10'(b_q.q400);
    div100   = (b_q.year[1:0] == 2'd0) && (b_q.year[YEAR_W-1:2] == q100_x25);
    div400   = (b_q.year[3:0] == 4'd0) && (b_q.year[YEAR_W-1:4] == q400_x25);
    leap     = ((b_q.year[1:0] == 2'd0) && !div100) || div400;
    month_ok = (b_q.month != '0) && (b_q.month <= MONTH_DEC);
    cur_len  = month_length(b_q.month, leap);
    prev_m   = (b_q.month == MONTH_JAN) ? MONTH_DEC : b_q.month - 4'd1;
    next_m   = (b_q.month == MONTH_DEC) ? MONTH_JAN : b_q.month + 4'd1;

    // Quotients of year-1: drop one where year itself divides evenly.
    y1      = b_q.year - 14'd1;
    y1_q100 = b_q.q100 - 8'(div100);
    y1_q400 = b_q.q400 - 6'(div400);

    c_next.ctx.invalid    = (b_q.day == '0) || !month_ok || (b_q.year == '0) ||
                            (b_q.day > cur_len);
    c_next.ctx.day        = b_q.day;
    c_next.ctx.month      = b_q.month;
    c_next.ctx.prev_month = prev_m;
    c_next.ctx.next_month = next_m;
    c_next.ctx.cur_len    = cur_len;
    c_next.ctx.prev_len   = month_length(prev_m, leap);
    c_next.day_sum        = 15'(y1) + 15'(y1[YEAR_W-1:2]) + 15'(WEEK_BIAS - y1_q100) +
                            15'(y1_q400) + 15'(days_before(b_q.month)) +
                            15'((b_q.month > MONTH_FEB) && leap) + 15'd1;
  end

  always_ff @(posedge clk) begin
    if (c_ready && b_valid) c_q <= c_next;
  end

  // --------------------------------------------------------------------------
  // Stage C -> generator: weekday of the first = day_sum mod 7, by folding
  // 3-bit digits (8 == 1 mod 7), then the starting cell of the grid.
  // --------------------------------------------------------------------------
  logic [5:0]         fold1;
  logic [3:0]         fold2;
  logic [COL_W-1:0]   first_wd;
  grid_phase_t        start_phase;
  logic [DAY_W-1:0]   start_day;

  always_comb begin
    fold1 = 6'(c_q.day_sum[2:0]) + 6'(c_q.day_sum[5:3]) + 6'(c_q.day_sum[8:6]) +
            6'(c_q.day_sum[11:9]) + 6'(c_q.day_sum[14:12]);
    fold2 = 4'(fold1[2:0]) + 4'(fold1[5:3]);
    first_wd = (fold2 >= 4'd7) ? 3'(fold2 - 4'd7) : fold2[2:0];
    if (first_wd == '0) begin
      start_phase = PHASE_CUR;
      start_day   = 5'd1;
    end else begin
      start_phase = PHASE_PREV;
      start_day   = c_q.ctx.prev_len - 5'(first_wd) + 5'd1;
    end
  end

  // --------------------------------------------------------------------------
  // Grid generator: walks a valid date's 42 cells, one per output transaction slot.
  // --------------------------------------------------------------------------
  grid_ctx_t           ctx;
  logic [CELL_IDX_W-1:0] cell_index, cell_index_next;
  grid_phase_t         grid_phase, grid_phase_next;
  logic [DAY_W-1:0]    running_day, running_day_next;
  logic [ROW_W-1:0]    row, row_next;
  logic [COL_W-1:0]    col, col_next;

  assign gen_last = ctx.invalid || (cell_index == CELL_IDX_W'(GRID_CELLS - 1));

  // Next cell within the grid.
  always_comb begin
    grid_phase_next  = grid_phase;
    running_day_next = running_day + 5'd1;
    cell_index_next  = cell_index + 6'd1;
    if (col == COL_W'(GRID_COLS - 1)) begin
      col_next = '0;
      row_next = row + 3'd1;
    end else begin
      col_next = col + 3'd1;
      row_next = row;
    end
    unique case (grid_phase)
      PHASE_PREV: begin
        if (running_day >= ctx.prev_len) begin
          grid_phase_next  = PHASE_CUR;
          running_day_next = 5'd1;
        end
      end
      PHASE_CUR: begin
        if (running_day >= ctx.cur_len) begin
          grid_phase_next  = PHASE_NEXT;
          running_day_next = 5'd1;
        end
      end
      PHASE_NEXT: ;
      default: begin
        grid_phase_next  = grid_phase;
        running_day_next = running_day;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gen_busy    <= 1'b0;
      cell_index  <= '0;
      grid_phase  <= PHASE_PREV;
      running_day <= '0;
      row         <= '0;
      col         <= '0;
    end else if (gen_load) begin
      gen_busy    <= 1'b1;
      cell_index  <= '0;
      grid_phase  <= start_phase;
      running_day <= start_day;
      row         <= '0;
      col         <= '0;
    end else if (gen_emit) begin
      if (gen_last) begin
        gen_busy    <= 1'b0;
        cell_index  <= '0;
        grid_phase  <= PHASE_PREV;
        running_day <= '0;
        row         <= '0;
        col         <= '0;
      end else begin
        cell_index  <= cell_index_next;
        grid_phase  <= grid_phase_next;
        running_day <= running_day_next;
        row         <= row_next;
        col         <= col_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (gen_load) ctx <= c_q.ctx;
  end

  // --------------------------------------------------------------------------
  // Cell fields of the current generator position.
  // --------------------------------------------------------------------------
  logic [MONTH_W-1:0] cell_month;
  logic               hol_hit;
  logic [DAY_W-1:0]   o_day;
  logic [KIND_W-1:0]  o_kind;
  logic [ROW_W-1:0]   o_row;
  logic [COL_W-1:0]   o_col;
  logic               o_red, o_sel;

  always_comb begin
    unique case (grid_phase)
      PHASE_PREV: cell_month = ctx.prev_month;
      PHASE_CUR:  cell_month = ctx.month;
      PHASE_NEXT: cell_month = ctx.next_month;
      default:    cell_month = ctx.month;
    endcase
    hol_hit = ((running_day == hol1_day) && (cell_month == hol1_month)) ||
              ((running_day == hol2_day) && (cell_month == hol2_month));
    if (ctx.invalid) begin
      // Error result: every field but date_invalid and last_cell is zero.
      o_day  = '0;
      o_kind = '0;
      o_row  = '0;
      o_col  = '0;
      o_red  = 1'b0;
      o_sel  = 1'b0;
    end else begin
      o_day  = running_day;
      o_kind = grid_phase;
      o_row  = row;
      o_col  = col;
      o_red  = (col == '0) || hol_hit;
      o_sel  = (grid_phase == PHASE_CUR) && (running_day == ctx.day);
    end
  end

  // --------------------------------------------------------------------------
  // Output register: hold the cell until its transaction completes.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_room) begin
      out_valid <= gen_busy;
    end
  end

  always_ff @(posedge clk) begin
    if (gen_emit) begin
      grid.cell_day        <= o_day;
      grid.cell_month_kind <= o_kind;
      grid.cell_row        <= o_row;
      grid.cell_column     <= o_col;
      grid.is_red          <= o_red;
      grid.is_selected     <= o_sel;
      grid.date_invalid    <= ctx.invalid;
      grid.last_cell       <= gen_last;
    end
  end

  assign grid.valid = out_valid;

endmodule

`default_nettype wire

>>> design/mcg_checker.sv
// ----------------------------------------------------------------------------
// mcg_checker
// Port-level checks of the month calendar grid core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module mcg_checker import mcg_pkg::*; (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              cell_valid,
  input wire logic              cell_ready,
  input wire logic [DAY_W-1:0]  cell_day,
  input wire logic [KIND_W-1:0] cell_month_kind,
  input wire logic [ROW_W-1:0]  cell_row,
  input wire logic [COL_W-1:0]  cell_column,
  input wire logic              is_red,
  input wire logic              is_selected,
  input wire logic              date_invalid,
  input wire logic              last_cell
);

  // An invalid date is one bare result.
  `MCG_ASSERT_IMPLIES(a_invalid_bare, clk, rst, cell_valid && date_invalid, last_cell && cell_day == '0 && cell_month_kind == '0 && cell_row == '0 && cell_column == '0 && !is_red && !is_selected, "invalid date result carries cell data")

  // Sunday column is always red.
  `MCG_ASSERT_IMPLIES(a_sunday_red, clk, rst, cell_valid && !date_invalid && cell_column == '0, is_red, "Sunday cell not red")

  // A grid ends exactly at its bottom right cell.
  `MCG_ASSERT_IMPLIES(a_last_corner, clk, rst, cell_valid && !date_invalid, last_cell == (cell_row == ROW_W'(GRID_ROWS - 1) && cell_column == COL_W'(GRID_COLS - 1)), "last flag off the grid corner")

  // Only a day of the given month can be selected.
  `MCG_ASSERT_IMPLIES(a_select_current, clk, rst, cell_valid && is_selected, cell_month_kind == KIND_W'(PHASE_CUR), "selected cell outside given month")

  // A stalled result holds.
  `MCG_ASSERT_NEXT(a_stall_hold, clk, rst, cell_valid && !cell_ready, cell_valid && $stable(cell_day) && $stable(last_cell) && $stable(cell_column), "stalled result changed")

endmodule

bind month_calendar_grid_generator_core mcg_checker u_mcg_checker (
  .clk             (clk),
  .rst             (rst),
  .cell_valid      (grid.valid),
  .cell_ready      (grid.ready),
  .cell_day        (grid.cell_day),
  .cell_month_kind (grid.cell_month_kind),
  .cell_row        (grid.cell_row),
  .cell_column     (grid.cell_column),
  .is_red          (grid.is_red),
  .is_selected     (grid.is_selected),
  .date_invalid    (grid.date_invalid),
  .last_cell       (grid.last_cell)
);

`default_nettype wire
